// ===== hw/rtl/hpt_pkg.sv =====
// Package for the header parameter tokenizer: tokenizer states, character
// constants, register indexes and the escape translation function.
// No dependencies.
`timescale 1ns / 1ps

package hpt_pkg;

  typedef enum logic [4:0] {
    ST_OUT  = 5'b00001,
    ST_NAME = 5'b00010,
    ST_VAL  = 5'b00100,
    ST_STR  = 5'b01000,
    ST_ESC  = 5'b10000
  } stage_t;

  localparam logic [7:0] CH_BLANK     = 8'd32;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_QUOTE     = 8'd34;
  localparam logic [7:0] CH_APOS      = 8'd39;
  localparam logic [7:0] CH_UNKNOWN   = 8'd63;

  localparam logic [7:0] SEPARATOR_RESET = 8'd59;
  localparam logic [7:0] ASSIGN_RESET    = 8'd61;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        REG_SEPARATOR = 1'b0;
  localparam logic        REG_ASSIGN    = 1'b1;

  // Escaped character to control code (backslash and quotes map to themselves); anything unknown becomes '?'.
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_BACKSLASH: r = CH_BACKSLASH;
      CH_APOS:      r = CH_APOS;
      CH_QUOTE:     r = CH_QUOTE;
      8'd97:        r = 8'd7;   // a
      8'd98:        r = 8'd8;   // b
      8'd102:       r = 8'd12;  // f
      8'd110:       r = 8'd10;  // n
      8'd114:       r = 8'd13;  // r
      8'd116:       r = 8'd9;   // t
      8'd118:       r = 8'd11;  // v
      default:      r = CH_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/hpt_if.sv =====
// Stream interfaces of the header parameter tokenizer: character beats in,
// token beats out. Depends on nothing.
`timescale 1ns / 1ps

interface hpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface hpt_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] out_char;
  logic       in_value;
  logic       pair_end;
  logic       pair_named;
  logic       pair_first;
  logic       string_done;

  modport source (output valid, output has_char, output out_char, output in_value,
                  output pair_end, output pair_named, output pair_first,
                  output string_done, input ready);
  modport sink (input valid, input has_char, input out_char, input in_value,
                input pair_end, input pair_named, input pair_first,
                input string_done, output ready);
endinterface

// ===== hw/rtl/header_parameter_tokenizer.sv =====
// Header parameter tokenizer top level: state update logic, result register
// and APB register port. Depends on hpt_pkg and the interfaces in hpt_if.sv.
//
//   channel   dir  payload                                            handshake
//   chars     in   char_code[7:0], is_last                            valid/ready
//   tokens    out  has_char, out_char[7:0], in_value, pair_end,       valid/ready
//                  pair_named, pair_first, string_done
//   apb       in   separator_char at 0x0, assign_char at 0x4          psel/penable
//
// Each character beat yields one token beat, registered and valid in the cycle after acceptance.
// One beat per cycle is sustained while tokens.ready is high; the only buffer is the result register.
// A stalled token beat holds chars.ready low only while the register is full
// and not being drained. Reset (rst, synchronous) returns the tokenizer to the
// outside state and restores the default separator and assign characters.
`timescale 1ns / 1ps

module header_parameter_tokenizer (
  input  logic                            clk,
  input  logic                            rst,
  hpt_in_if.sink                          chars,
  hpt_out_if.source                       tokens,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hpt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [7:0]      separator_char;
  logic [7:0]      assign_char;
  hpt_pkg::stage_t stage;
  hpt_pkg::stage_t stage_next;
  logic            name_nonempty;
  logic            name_nonempty_next;
  logic            first_taken;
  logic            first_taken_next;

  logic            accept;
  logic            has;
  logic [7:0]      ch;
  logic            inval;
  logic            pend;
  logic            pnamed;
  logic            pfirst;
  logic [7:0]      c;
  hpt_pkg::stage_t cur;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hpt_pkg::REG_ASSIGN) ? {24'd0, assign_char}
                                                    : {24'd0, separator_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= hpt_pkg::SEPARATOR_RESET;
      assign_char    <= hpt_pkg::ASSIGN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == hpt_pkg::REG_ASSIGN) begin
        assign_char <= pwdata[7:0];
      end else begin
        separator_char <= pwdata[7:0];
      end
    end
  end

  assign chars.ready = !tokens.valid || tokens.ready;
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.char_code;

  always_comb begin
    has                = 1'b0;
    ch                 = 8'd0;
    inval              = 1'b0;
    pend               = 1'b0;
    pnamed             = 1'b0;
    pfirst             = 1'b0;
    name_nonempty_next = name_nonempty;
    first_taken_next   = first_taken;

    // Outside (and any stray code): blanks and tabs are skipped, anything
    // else opens a name and is handled there in the same beat.
    case (stage)
      hpt_pkg::ST_NAME,
      hpt_pkg::ST_VAL,
      hpt_pkg::ST_STR,
      hpt_pkg::ST_ESC: cur = stage;
      default: begin
        cur = (c == hpt_pkg::CH_BLANK || c == hpt_pkg::CH_TAB) ? hpt_pkg::ST_OUT
                                                               : hpt_pkg::ST_NAME;
      end
    endcase
    stage_next = cur;

    case (cur)
      hpt_pkg::ST_NAME: begin
        if (c == separator_char) begin
          pend               = 1'b1;
          name_nonempty_next = 1'b0;
          stage_next         = hpt_pkg::ST_OUT;
        end else if (c == assign_char) begin
          stage_next = hpt_pkg::ST_VAL;
        end else begin
          has                = 1'b1;
          ch                 = c;
          name_nonempty_next = 1'b1;
        end
      end
      hpt_pkg::ST_ESC: begin
        has        = 1'b1;
        ch         = hpt_pkg::map_escape(c);
        inval      = 1'b1;
        stage_next = hpt_pkg::ST_STR;
      end
      hpt_pkg::ST_STR: begin
        if (c == hpt_pkg::CH_BACKSLASH) begin
          stage_next = hpt_pkg::ST_ESC;
        end else if (c == hpt_pkg::CH_QUOTE) begin
          stage_next = hpt_pkg::ST_VAL;
        end else begin
          has   = 1'b1;
          ch    = c;
          inval = 1'b1;
        end
      end
      hpt_pkg::ST_VAL: begin
        if (c == hpt_pkg::CH_QUOTE) begin
          stage_next = hpt_pkg::ST_STR;
        end else if (c == separator_char) begin
          pend               = 1'b1;
          pnamed             = 1'b1;
          pfirst             = !first_taken;
          first_taken_next   = 1'b1;
          name_nonempty_next = 1'b0;
          stage_next         = hpt_pkg::ST_OUT;
        end else begin
          has   = 1'b1;
          ch    = c;
          inval = 1'b1;
        end
      end
      default: begin
        stage_next = hpt_pkg::ST_OUT;
      end
    endcase

    // The last character flushes a pending name, then everything restarts.
    if (chars.is_last) begin
      if (name_nonempty_next) begin
        pend   = 1'b1;
        pnamed = (stage_next == hpt_pkg::ST_VAL);
        pfirst = (stage_next == hpt_pkg::ST_VAL) && !first_taken;
      end
      stage_next         = hpt_pkg::ST_OUT;
      name_nonempty_next = 1'b0;
      first_taken_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= hpt_pkg::ST_OUT;
      name_nonempty <= 1'b0;
      first_taken   <= 1'b0;
      tokens.valid  <= 1'b0;
    end else begin
      if (accept) begin
        stage         <= stage_next;
        name_nonempty <= name_nonempty_next;
        first_taken   <= first_taken_next;
        tokens.valid  <= 1'b1;
      end else if (tokens.ready) begin
        tokens.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tokens.has_char    <= has;
      tokens.out_char    <= ch;
      tokens.in_value    <= inval;
      tokens.pair_end    <= pend;
      tokens.pair_named  <= pnamed;
      tokens.pair_first  <= pfirst;
      tokens.string_done <= chars.is_last;
    end
  end

endmodule

// ===== hw/rtl/hpt_checker.sv =====
// Port-level checks for the header parameter tokenizer, attached by bind.
// Depends on the header_parameter_tokenizer top level and hpt_if.sv.
`timescale 1ns / 1ps

module hpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_char,
  input logic [7:0] out_char,
  input logic       in_value,
  input logic       pair_end,
  input logic       pair_named,
  input logic       pair_first
);

  // A stalled token beat keeps its character and pair-end flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(pair_end))
    else $error("token beat changed while stalled");

  // Every accepted character beat shows up as a token beat in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted character produced no token beat");

  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("token beat valid right after reset");

  // Pair flags only ride on a pair end, and a first pair is always named.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_end || (!pair_named && !pair_first)) && (!pair_first || pair_named))
    else $error("pair flags without a named pair end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> out_char == 8'd0 && !in_value)
    else $error("character fields set without a character");

endmodule

bind header_parameter_tokenizer hpt_checker u_hpt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .has_char   (tokens.has_char),
  .out_char   (tokens.out_char),
  .in_value   (tokens.in_value),
  .pair_end   (tokens.pair_end),
  .pair_named (tokens.pair_named),
  .pair_first (tokens.pair_first)
);
